### rtl/mggs_pkg.sv
// ============================================================================
// mggs_pkg: shared types and constants of the masked Gaussian grid smoother
// Widths of the cell words, weights and accumulators, the sequencer states,
// the register map and the control word that drives the accumulator.
// ============================================================================
package mggs_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int VALUE_W  = 32;               // Q16.16 cell value
    localparam int CELL_W   = VALUE_W + 1;      // valid mark above the value
    localparam int WEIGHT_W = 17;               // Q1.16 weight, up to 1.0
    localparam int PROD_W   = VALUE_W + WEIGHT_W + 1;
    localparam int ACC_W    = 56;               // 25 products of 50 bits
    localparam int WSUM_W   = 21;               // 25 weights of at most 1.0
    localparam int COORD_W  = 6;
    localparam int DIM_W    = 7;
    localparam int RADIUS_W = 2;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [RADIUS_W-1:0] MAX_RADIUS = 2'd2;

    localparam logic [DIM_W-1:0]    RST_GRID_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]    RST_GRID_HEIGHT = 7'd64;
    localparam logic [RADIUS_W-1:0] RST_RADIUS      = 2'd2;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT1     = 17'd39750;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT2     = 17'd24109;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT4     = 17'd8869;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT5     = 17'd5380;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT8     = 17'd1200;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_KERNEL_RADIUS,
        REG_WEIGHT_DIST1,
        REG_WEIGHT_DIST2,
        REG_WEIGHT_DIST4,
        REG_WEIGHT_DIST5,
        REG_WEIGHT_DIST8
    } mggs_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_OUTPUT
    } mggs_state_t;

    // Control word from the sequencer to the multiply-accumulate pipeline.
    typedef struct packed {
        logic                clear;   // start of a query: empty the sums
        logic                issue;   // a tap inside the grid was read
        logic [WEIGHT_W-1:0] weight;  // weight of that tap
    } mggs_mac_ctl_t;

    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
        return (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

endpackage

### rtl/mggs_ram.sv
// ============================================================================
// mggs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module mggs_ram #(
    parameter int   DATA_W = 33,
    parameter int   DEPTH  = 4096,
    localparam int  ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mggs_mac.sv
// ============================================================================
// mggs_mac: weighted-sum pipeline of the smoother
// Multiplies each valid neighbour value by its weight and accumulates the
// products and the weights, one tap per cycle, three stages deep.
// ============================================================================
module mggs_mac
    import mggs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mggs_mac_ctl_t            ctl,
    input  logic [CELL_W-1:0]        rd_data,
    output logic signed [ACC_W-1:0]  acc_sum,
    output logic [WSUM_W-1:0]        acc_wsum
);

    logic                       tap_live_reg;
    logic [WEIGHT_W-1:0]        tap_weight_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [WEIGHT_W-1:0]        prod_wt_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic [WSUM_W-1:0]          wsum_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic [WEIGHT_W-1:0]        prod_wt_next;

    // The read data lines up with the tap registered in the previous cycle.
    always_comb begin
        if (tap_live_reg && rd_data[CELL_W-1]) begin
            prod_next    = $signed(rd_data[VALUE_W-1:0]) * $signed({1'b0, tap_weight_reg});
            prod_wt_next = tap_weight_reg;
        end else begin
            prod_next    = '0;
            prod_wt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            tap_live_reg   <= 1'b0;
            tap_weight_reg <= '0;
            prod_reg       <= '0;
            prod_wt_reg    <= '0;
            sum_reg        <= '0;
            wsum_reg       <= '0;
        end else begin
            tap_live_reg   <= ctl.issue;
            tap_weight_reg <= ctl.weight;
            prod_reg       <= prod_next;
            prod_wt_reg    <= prod_wt_next;
            sum_reg        <= sum_reg + ACC_W'(prod_reg);
            wsum_reg       <= wsum_reg + WSUM_W'(prod_wt_reg);
        end
    end

    assign acc_sum  = sum_reg;
    assign acc_wsum = wsum_reg;

endmodule

### rtl/mggs_div.sv
// ============================================================================
// mggs_div: serial signed divider of the smoother
// Divides the weighted sum by the weight sum one quotient bit per cycle,
// truncating toward zero. The quotient is known to fit in 32 bits.
// ============================================================================
module mggs_div
    import mggs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  dividend,
    input  logic [WSUM_W-1:0]        divisor,
    output logic                     done,
    output logic [VALUE_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(VALUE_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [WSUM_W-1:0]   rem_reg;
    logic [VALUE_W-1:0]  shf_reg;
    logic                neg_reg;
    logic [WSUM_W-1:0]   divisor_reg;
    logic [ACC_W-1:0]    mag;
    logic [WSUM_W:0]     trial;
    logic                qbit;

    assign mag   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
    assign trial = {rem_reg, shf_reg[VALUE_W-1]};
    assign qbit  = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // The upper part of the magnitude is below the divisor, so the remainder
    // starts there and only the low 32 bits need to be shifted through.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= WSUM_W'(mag >> VALUE_W);
            shf_reg     <= mag[VALUE_W-1:0];
            neg_reg     <= dividend[ACC_W-1];
            divisor_reg <= divisor;
        end else if (busy_reg && cnt_reg != LAST_STEP) begin
            rem_reg <= qbit ? WSUM_W'(trial - {1'b0, divisor_reg}) : WSUM_W'(trial);
            shf_reg <= {shf_reg[VALUE_W-2:0], qbit};
        end
    end

    assign done     = busy_reg && (cnt_reg == LAST_STEP);
    assign quotient = neg_reg ? VALUE_W'(-shf_reg) : shf_reg;

endmodule

### rtl/masked_gaussian_grid_smoother_unit.sv
// ============================================================================
// masked_gaussian_grid_smoother_unit: masked Gaussian grid smoother
// Stores a grid of Q16.16 values with valid marks and answers queries with
// the normalized Gaussian-weighted mean of the valid cells around a cell.
// ============================================================================
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata: col, row, cell_value,
//                                           cell_valid; s_tuser: kind
//  m_        out        m_tvalid/m_tready   m_tdata: smoothed_value;
//                                           m_tuser: centre_valid
//  apb       in         psel/penable        8 registers at byte address 4*i
//
// A load word is written to the cell RAM in the cycle it is accepted.
// A query reads its centre, then one RAM word per neighbour within kernel
// radius r through the shared multiply-accumulate pipeline; it drains the
// pipeline and runs a one-bit-per-cycle divider. A masked or off-grid centre
// skips to the output. The input is ready only between queries; a result
// waiting in the output register does not stop the next word from entering.
// Reset is synchronous and active low; the cell RAM is not cleared.
//
module masked_gaussian_grid_smoother_unit
    import mggs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // tdata: [5:0] col, [11:6] row, [43:12] cell_value, [44] cell_valid
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,
    input  logic               s_tuser,    // [0] kind
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,    // [31:0] smoothed_value
    output logic               m_tuser,    // [0] centre_valid
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] WIDTH_CAP  =
        (MAX_WIDTH > 127) ? 7'd127 : DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_CAP =
        (MAX_HEIGHT > 127) ? 7'd127 : DIM_W'(MAX_HEIGHT);
    // Drain count at which the sums hold the product of the last neighbour read.
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    // Configuration registers.
    logic [DIM_W-1:0]    grid_width_reg;
    logic [DIM_W-1:0]    grid_height_reg;
    logic [RADIUS_W-1:0] kernel_radius_reg;
    logic [WEIGHT_W-1:0] weight1_reg;
    logic [WEIGHT_W-1:0] weight2_reg;
    logic [WEIGHT_W-1:0] weight4_reg;
    logic [WEIGHT_W-1:0] weight5_reg;
    logic [WEIGHT_W-1:0] weight8_reg;
    logic                cfg_write;

    // Input word fields.
    logic [COORD_W-1:0]  in_col;
    logic [COORD_W-1:0]  in_row;
    logic [VALUE_W-1:0]  in_value;
    logic                in_valid;
    logic                s_fire;

    // Sequencer state.
    mggs_state_t         state_reg, state_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic                centre_in_reg, centre_in_next;
    logic signed [2:0]   dx_reg, dx_next;
    logic signed [2:0]   dy_reg, dy_next;
    logic [1:0]          drain_reg, drain_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                res_ok_reg, res_ok_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    // Datapath.
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic [RADIUS_W-1:0]  rad;
    logic signed [2:0]    rad_pos;
    logic signed [2:0]    rad_neg;
    logic signed [8:0]    nx;
    logic signed [8:0]    ny;
    logic                 tap_inside;
    logic [1:0]           adx;
    logic [1:0]           ady;
    logic [WEIGHT_W-1:0]  tap_wt;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;
    mggs_mac_ctl_t        mac_ctl;
    logic signed [ACC_W-1:0] acc_sum;
    logic [WSUM_W-1:0]    acc_wsum;
    logic                 div_start;
    logic                 div_done;
    logic [VALUE_W-1:0]   div_quot;

    // Neighbour coordinates can run two cells past the last column or row a
    // word can name, so the coordinate inputs take one bit more than the fields.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W:0] r,
                                                   input logic [COORD_W:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c));
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Registers keep what was written; saturation of
    // the grid size, radius and weights is applied where they are used.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg    <= RST_GRID_WIDTH;
            grid_height_reg   <= RST_GRID_HEIGHT;
            kernel_radius_reg <= RST_RADIUS;
            weight1_reg       <= RST_WEIGHT1;
            weight2_reg       <= RST_WEIGHT2;
            weight4_reg       <= RST_WEIGHT4;
            weight5_reg       <= RST_WEIGHT5;
            weight8_reg       <= RST_WEIGHT8;
        end else if (cfg_write) begin
            case (mggs_reg_t'(paddr[4:2]))
                REG_GRID_WIDTH:    grid_width_reg    <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT:   grid_height_reg   <= pwdata[DIM_W-1:0];
                REG_KERNEL_RADIUS: kernel_radius_reg <= pwdata[RADIUS_W-1:0];
                REG_WEIGHT_DIST1:  weight1_reg       <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_DIST2:  weight2_reg       <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_DIST4:  weight4_reg       <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_DIST5:  weight5_reg       <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_DIST8:  weight8_reg       <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (mggs_reg_t'(paddr[4:2]))
            REG_GRID_WIDTH:    prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT:   prdata = PDATA_W'(grid_height_reg);
            REG_KERNEL_RADIUS: prdata = PDATA_W'(kernel_radius_reg);
            REG_WEIGHT_DIST1:  prdata = PDATA_W'(weight1_reg);
            REG_WEIGHT_DIST2:  prdata = PDATA_W'(weight2_reg);
            REG_WEIGHT_DIST4:  prdata = PDATA_W'(weight4_reg);
            REG_WEIGHT_DIST5:  prdata = PDATA_W'(weight5_reg);
            REG_WEIGHT_DIST8:  prdata = PDATA_W'(weight8_reg);
            default:           prdata = '0;
        endcase
    end

    // Effective grid size and radius after saturation.
    assign w_eff   = (grid_width_reg > WIDTH_CAP) ? WIDTH_CAP : grid_width_reg;
    assign h_eff   = (grid_height_reg > HEIGHT_CAP) ? HEIGHT_CAP : grid_height_reg;
    assign rad     = (kernel_radius_reg > MAX_RADIUS) ? MAX_RADIUS : kernel_radius_reg;
    assign rad_pos = {1'b0, rad};
    assign rad_neg = -rad_pos;

    // ------------------------------------------------------------------
    // Input word and cell RAM. A load goes straight into the RAM; a load
    // outside the store is dropped. A query reads its centre at once.
    // ------------------------------------------------------------------
    assign in_col   = s_tdata[5:0];
    assign in_row   = s_tdata[11:6];
    assign in_value = s_tdata[43:12];
    assign in_valid = s_tdata[44];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign ram_we    = s_fire && (s_tuser == KIND_LOAD)
                       && (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
    assign ram_waddr = cell_addr({1'b0, in_row}, {1'b0, in_col});

    // Neighbour position of the current tap; only taps inside the grid count.
    assign nx = $signed({3'b000, col_reg}) + 9'(dx_reg);
    assign ny = $signed({3'b000, row_reg}) + 9'(dy_reg);
    assign tap_inside = !nx[8] && !ny[8]
                        && (nx < $signed({2'b00, w_eff})) && (ny < $signed({2'b00, h_eff}));

    assign ram_raddr = (state_reg == ST_IDLE) ? cell_addr({1'b0, in_row}, {1'b0, in_col})
                                              : cell_addr(ny[6:0], nx[6:0]);

    mggs_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (DEPTH)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_valid, in_value}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Weight by squared distance: the centre is 1.0, the others come from
    // the registers, picked by the absolute offsets.
    assign adx = 2'(dx_reg[2] ? -dx_reg : dx_reg);
    assign ady = 2'(dy_reg[2] ? -dy_reg : dy_reg);

    always_comb begin
        case ({adx, ady})
            4'b0000:          tap_wt = ONE_Q16;
            4'b0001, 4'b0100: tap_wt = sat_weight(weight1_reg);
            4'b0101:          tap_wt = sat_weight(weight2_reg);
            4'b0010, 4'b1000: tap_wt = sat_weight(weight4_reg);
            4'b0110, 4'b1001: tap_wt = sat_weight(weight5_reg);
            4'b1010:          tap_wt = sat_weight(weight8_reg);
            default:          tap_wt = '0;
        endcase
    end

    assign mac_ctl.clear  = s_fire && (s_tuser == KIND_QUERY);
    assign mac_ctl.issue  = (state_reg == ST_SCAN) && tap_inside;
    assign mac_ctl.weight = tap_wt;

    mggs_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .rd_data  (ram_rdata),
        .acc_sum  (acc_sum),
        .acc_wsum (acc_wsum)
    );

    assign div_start = (state_reg == ST_DRAIN) && (drain_reg == DRAIN_LAST);

    mggs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (acc_wsum),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer: centre check, neighbour scan row by row, pipeline drain,
    // division, then hand the result to the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            drain_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            drain_reg    <= drain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        centre_in_reg <= centre_in_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        res_value_reg <= res_value_next;
        res_ok_reg    <= res_ok_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        centre_in_next = centre_in_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        drain_next     = drain_reg;
        res_value_next = res_value_reg;
        res_ok_next    = res_ok_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_tuser == KIND_QUERY)) begin
                    col_next       = in_col;
                    row_next       = in_row;
                    centre_in_next = ({1'b0, in_col} < w_eff) && ({1'b0, in_row} < h_eff);
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // The centre word is on the RAM output now.
                if (!centre_in_reg || !ram_rdata[CELL_W-1]) begin
                    res_value_next = '0;
                    res_ok_next    = 1'b0;
                    state_next     = ST_OUTPUT;
                end else begin
                    dx_next    = rad_neg;
                    dy_next    = rad_neg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (dx_reg == rad_pos) begin
                    dx_next = rad_neg;
                    dy_next = dy_reg + 3'sd1;
                    if (dy_reg == rad_pos) begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                end else begin
                    dx_next = dx_reg + 3'sd1;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == DRAIN_LAST) begin
                    state_next = ST_DIVIDE;
                end else begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    res_value_next = div_quot;
                    res_ok_next    = 1'b1;
                    state_next     = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = res_ok_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### tb/masked_gaussian_grid_smoother_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// masked_gaussian_grid_smoother_unit_tb: self-checking bench for the smoother
// Loads grid cells and queries smoothed values over the stream channels while
// both sides idle at random. Each accepted word is also applied to a shadow
// grid that predicts every result, and the output is compared word by word.
// ============================================================================
module masked_gaussian_grid_smoother_unit_tb;
    import mggs_pkg::*;

    localparam int STORE_CELLS    = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int WORDS_PER_PASS = 148;   // random words after each register setting
    localparam int PASS_COUNT     = 13;
    localparam int DRAIN_CYCLES   = 100;   // longer than one radius-2 query
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    // One input word as the stream carries it.
    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [VALUE_W-1:0] cell_value;
        logic               cell_valid;
    } grid_word_t;

    // One result word.
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               centre_valid;
    } smooth_result_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata  = '0;   // [5:0] col, [11:6] row, [43:12] cell_value, [44] cell_valid
    logic               s_tuser  = 1'b0; // [0] kind
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;         // [31:0] smoothed_value
    logic               m_tuser;         // [0] centre_valid
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Words waiting to be sent; the head is the one on the bus while s_tvalid is high.
    grid_word_t        pending_grid_words [$];
    // Smoothed values predicted for accepted queries, oldest first.
    smooth_result_t    expected_smooth [$];
    // Shadow of the cell RAM and of the register file, updated on acceptance.
    logic [CELL_W-1:0] cell_mirror [STORE_CELLS];
    logic [31:0]       reg_shadow [8];
    // Cells that some queued load writes; a query is only queued once its
    // whole 5x5 neighbourhood is in here, so no unwritten RAM word is read.
    bit                cell_planned [STORE_CELLS];

    int  words_planned = 0;
    int  last_col      = 0;
    int  last_row      = 0;
    int  fault_count   = 0;
    int  quiet_cycles  = 0;
    int  burst_left    = 0;
    int  gap_left      = 0;
    int  stall_mode    = 0;
    int  mode_cycles   = 0;
    bit  word_taken    = 1'b0;

    masked_gaussian_grid_smoother_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int cell_index(input int col, input int row);
        return row * DEF_MAX_WIDTH + col;
    endfunction

    // Grid width or height in use; values above the store size act as the store size.
    function automatic int grid_extent(input mggs_reg_t idx, input int limit);
        return (reg_shadow[idx] > limit) ? limit : int'(reg_shadow[idx]);
    endfunction

    // Weight of a neighbour by squared distance. The centre is fixed at 1.0, the
    // programmed weights are clamped to 1.0, and the corners of the 5x5 window
    // that lie further away than distance-squared eight cannot occur.
    function automatic longint tap_weight(input int dist_sq);
        logic [31:0] w;
        case (dist_sq)
            0: return longint'(ONE_Q16);
            1: w = reg_shadow[REG_WEIGHT_DIST1];
            2: w = reg_shadow[REG_WEIGHT_DIST2];
            4: w = reg_shadow[REG_WEIGHT_DIST4];
            5: w = reg_shadow[REG_WEIGHT_DIST5];
            8: w = reg_shadow[REG_WEIGHT_DIST8];
            default: return 0;
        endcase
        return (w > ONE_Q16) ? longint'(ONE_Q16) : longint'(w);
    endfunction

    // Normalized convolution at one cell: sum of value*weight over the valid
    // neighbours inside the grid, divided by the sum of their weights with the
    // quotient truncated toward zero. Off-grid or masked centres give zero and
    // a cleared valid flag.
    function automatic smooth_result_t smooth_predict(input grid_word_t q);
        smooth_result_t    res;
        int                gw, gh, rad, dx, dy, nx, ny;
        longint            acc, wacc, wt;
        logic [CELL_W-1:0] nbr_word;
        res.value        = '0;
        res.centre_valid = 1'b0;
        gw  = grid_extent(REG_GRID_WIDTH, DEF_MAX_WIDTH);
        gh  = grid_extent(REG_GRID_HEIGHT, DEF_MAX_HEIGHT);
        rad = (reg_shadow[REG_KERNEL_RADIUS] > MAX_RADIUS) ?
              int'(MAX_RADIUS) : int'(reg_shadow[REG_KERNEL_RADIUS]);
        if (int'(q.col) >= gw || int'(q.row) >= gh) begin
            return res;
        end
        if (!cell_mirror[cell_index(int'(q.col), int'(q.row))][VALUE_W]) begin
            return res;
        end
        acc  = 0;
        wacc = 0;
        for (dy = -rad; dy <= rad; dy++) begin
            ny = int'(q.row) + dy;
            if (ny < 0 || ny >= gh) begin
                continue;
            end
            for (dx = -rad; dx <= rad; dx++) begin
                nx = int'(q.col) + dx;
                if (nx < 0 || nx >= gw) begin
                    continue;
                end
                nbr_word = cell_mirror[cell_index(nx, ny)];
                if (!nbr_word[VALUE_W]) begin
                    continue;
                end
                wt   = tap_weight(dx * dx + dy * dy);
                acc  += longint'($signed(nbr_word[VALUE_W-1:0])) * wt;
                wacc += wt;
            end
        end
        // The valid centre always adds 1.0, so the divisor is never zero.
        acc = acc / wacc;
        res.value        = acc[VALUE_W-1:0];
        res.centre_valid = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_weight();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65536;
            2: return int'($urandom_range(65537, 131071));
            default: return int'($urandom_range(0, 65536));
        endcase
    endfunction

    // Centre coordinate inside a grid dimension, biased toward its borders.
    function automatic int pick_coord(input int extent);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return extent - 1;
            default: return int'($urandom_range(0, extent - 1));
        endcase
    endfunction

    function automatic logic [31:0] reg_mask(input mggs_reg_t idx);
        case (idx)
            REG_GRID_WIDTH, REG_GRID_HEIGHT: return (32'd1 << DIM_W) - 1;
            REG_KERNEL_RADIUS:               return (32'd1 << RADIUS_W) - 1;
            default:                         return (32'd1 << WEIGHT_W) - 1;
        endcase
    endfunction

    task automatic queue_word(input logic kind, input int col, input int row,
                              input logic [31:0] value, input logic valid);
        grid_word_t w;
        w.kind       = kind;
        w.col        = COORD_W'(col);
        w.row        = COORD_W'(row);
        w.cell_value = value;
        w.cell_valid = valid;
        pending_grid_words.push_back(w);
        words_planned++;
        if (kind == KIND_LOAD) begin
            cell_planned[cell_index(col, row)] = 1'b1;
        end
    endtask

    // A load with random content; most cells end up inside the mask.
    task automatic queue_load(input int col, input int row);
        queue_word(KIND_LOAD, col, row, rand_value(), $urandom_range(0, 4) != 0);
    endtask

    // A query, preceded by loads for whatever part of its 5x5 window has never
    // been written. The payload of the query itself is junk that must be ignored.
    task automatic queue_query(input int col, input int row);
        int nx, ny;
        for (ny = row - 2; ny <= row + 2; ny++) begin
            for (nx = col - 2; nx <= col + 2; nx++) begin
                if (nx >= 0 && nx < DEF_MAX_WIDTH && ny >= 0 && ny < DEF_MAX_HEIGHT &&
                    !cell_planned[cell_index(nx, ny)]) begin
                    queue_load(nx, ny);
                end
            end
        end
        queue_word(KIND_QUERY, col, row, $urandom, $urandom_range(0, 1) == 1);
        last_col = col;
        last_row = row;
    endtask

    // Mostly queries around the grid in use, some reloads next to the last
    // query so that masks and values change under it, and some stray loads
    // anywhere in the store.
    task automatic run_random(input int count);
        int first, gw, gh, col, row;
        first = words_planned;
        gw    = grid_extent(REG_GRID_WIDTH, DEF_MAX_WIDTH);
        gh    = grid_extent(REG_GRID_HEIGHT, DEF_MAX_HEIGHT);
        while (words_planned - first < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    queue_load(int'($urandom_range(0, DEF_MAX_WIDTH - 1)),
                               int'($urandom_range(0, DEF_MAX_HEIGHT - 1)));
                end
                1, 2: begin
                    col = last_col + int'($urandom_range(0, 4)) - 2;
                    row = last_row + int'($urandom_range(0, 4)) - 2;
                    col = (col < 0) ? 0 : (col >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col;
                    row = (row < 0) ? 0 : (row >= DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT - 1 : row;
                    queue_load(col, row);
                end
                default: begin
                    // Sometimes aim anywhere, which with small grids lands off the grid.
                    if (gw == 0 || gh == 0 || $urandom_range(0, 7) == 0) begin
                        col = int'($urandom_range(0, DEF_MAX_WIDTH - 1));
                        row = int'($urandom_range(0, DEF_MAX_HEIGHT - 1));
                    end else begin
                        col = pick_coord(gw);
                        row = pick_coord(gh);
                    end
                    queue_query(col, row);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------

    // Setup cycle, access cycle, then the bus returns to idle. pready is
    // always high, so the register takes the value at the access edge.
    task automatic apb_write(input mggs_reg_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_shadow[idx] = value & reg_mask(idx);
    endtask

    task automatic program_grid(input int gw, input int gh, input int rad, input int w1,
                                input int w2, input int w4, input int w5, input int w8);
        apb_write(REG_GRID_WIDTH, gw);
        apb_write(REG_GRID_HEIGHT, gh);
        apb_write(REG_KERNEL_RADIUS, rad);
        apb_write(REG_WEIGHT_DIST1, w1);
        apb_write(REG_WEIGHT_DIST2, w2);
        apb_write(REG_WEIGHT_DIST4, w4);
        apb_write(REG_WEIGHT_DIST5, w5);
        apb_write(REG_WEIGHT_DIST8, w8);
    endtask

    // Wait until every queued word is accepted and every predicted result has
    // come back. A trailing load gives no result, so allow a query's worth of
    // cycles on top before the block is treated as idle.
    task automatic settle();
        while (pending_grid_words.size() != 0 || expected_smooth.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Acceptance: the word at the head of the queue has been taken. Loads go
    // into the shadow grid, queries get their result predicted right away,
    // since registers only change while the block is idle.
    always @(posedge aclk) begin : accept_path
        grid_word_t w;
        word_taken = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            w          = pending_grid_words.pop_front();
            word_taken = 1'b1;
            if (w.kind == KIND_LOAD) begin
                cell_mirror[cell_index(int'(w.col), int'(w.row))] = {w.cell_valid, w.cell_value};
            end else begin
                expected_smooth.push_back(smooth_predict(w));
            end
        end
    end

    // Sender: bursts of random length separated by random gaps, sometimes long
    // bursts with no gap at all. A word that is on the bus stays there until it
    // is taken.
    always @(negedge aclk) begin : send_path
        grid_word_t w;
        if (!(s_tvalid && !word_taken)) begin
            if (burst_left == 0 && gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_grid_words.size() != 0) begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(50, 200))
                                                             : int'($urandom_range(1, 12));
                end
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
                end
                w = pending_grid_words[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, w.cell_valid, w.cell_value, w.row, w.col};
                s_tuser  <= w.kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: switches every so often between always ready, coin flips,
    // mostly stalled, and a fixed one-in-three stall rhythm.
    always @(negedge aclk) begin
        if (mode_cycles == 0) begin
            stall_mode  = int'($urandom_range(0, 3));
            mode_cycles = int'($urandom_range(20, 300));
        end
        mode_cycles--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= (mode_cycles % 3 != 0);
        endcase
    end

    // Each result word is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        smooth_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_smooth.size() == 0) begin
                note_fault($sformatf("result with nothing expected: smoothed_value %h centre_valid %b",
                                     m_tdata, m_tuser));
            end else begin
                exp_r = expected_smooth.pop_front();
                if (m_tdata !== exp_r.value || m_tuser !== exp_r.centre_valid) begin
                    note_fault($sformatf("smoothed_value exp %h got %h, centre_valid exp %b got %b",
                                         exp_r.value, m_tdata, exp_r.centre_valid, m_tuser));
                end
            end
        end
    end

    // Watchdog: a run of cycles with no word moving on either channel means
    // the block is stuck or a result never came.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int pass;
        reg_shadow[REG_GRID_WIDTH]    = 32'(RST_GRID_WIDTH);
        reg_shadow[REG_GRID_HEIGHT]   = 32'(RST_GRID_HEIGHT);
        reg_shadow[REG_KERNEL_RADIUS] = 32'(RST_RADIUS);
        reg_shadow[REG_WEIGHT_DIST1]  = 32'(RST_WEIGHT1);
        reg_shadow[REG_WEIGHT_DIST2]  = 32'(RST_WEIGHT2);
        reg_shadow[REG_WEIGHT_DIST4]  = 32'(RST_WEIGHT4);
        reg_shadow[REG_WEIGHT_DIST5]  = 32'(RST_WEIGHT5);
        reg_shadow[REG_WEIGHT_DIST8]  = 32'(RST_WEIGHT8);
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset settings. The top-left corner holds the
        // largest positive and negative values, which drives the products and
        // the sum to their extremes, and the window is clipped by two borders.
        queue_word(KIND_LOAD, 0, 0, 32'h7FFF_FFFF, 1'b1);
        queue_word(KIND_LOAD, 1, 0, 32'h8000_0000, 1'b1);
        queue_word(KIND_LOAD, 0, 1, 32'h7FFF_FFFF, 1'b1);
        queue_word(KIND_LOAD, 1, 1, 32'h8000_0000, 1'b1);
        queue_query(0, 0);
        // A masked centre at the far corner, then the same cell made valid.
        queue_word(KIND_LOAD, DEF_MAX_WIDTH - 1, DEF_MAX_HEIGHT - 1, 32'hFFFF_FFFF, 1'b0);
        queue_query(DEF_MAX_WIDTH - 1, DEF_MAX_HEIGHT - 1);
        queue_word(KIND_LOAD, DEF_MAX_WIDTH - 1, DEF_MAX_HEIGHT - 1, 32'h7FFF_FFFF, 1'b1);
        queue_query(DEF_MAX_WIDTH - 1, DEF_MAX_HEIGHT - 1);
        run_random(WORDS_PER_PASS);

        // Each later pass rewrites every register while the block is idle.
        // The first ones cover the corners of the register space: a one-cell
        // grid with radius zero, radius three, oversize grids with weights
        // above one, zero width, zero height, and narrow or flat grids.
        for (pass = 1; pass < PASS_COUNT; pass++) begin
            settle();
            case (pass)
                1: program_grid(1, 1, 0, 0, 0, 0, 0, 0);
                2: program_grid(64, 64, 3, 65536, 65536, 65536, 65536, 65536);
                3: program_grid(127, 127, 2, 131071, 131071, 65537, 100000, 70000);
                4: program_grid(0, 64, 1, rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight());
                5: program_grid(96, 0, 2, rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight());
                6: program_grid(8, 8, 2, rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight());
                7: program_grid(5, 64, 1, rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight());
                8: program_grid(64, 3, 2, rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight());
                default: begin
                    program_grid(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 127))
                                                             : int'($urandom_range(1, 16)),
                                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 127))
                                                             : int'($urandom_range(1, 16)),
                                 int'($urandom_range(0, 3)), rand_weight(), rand_weight(),
                                 rand_weight(), rand_weight(), rand_weight());
                end
            endcase
            run_random(WORDS_PER_PASS);
        end

        settle();
        if (fault_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### masked_gaussian_grid_smoother_unit.f
rtl/mggs_pkg.sv
rtl/mggs_ram.sv
rtl/mggs_mac.sv
rtl/mggs_div.sv
rtl/masked_gaussian_grid_smoother_unit.sv
tb/masked_gaussian_grid_smoother_unit_tb.sv
